FILE: src/msp_pkg.sv
// Shared types and constants for the memory size string parser.
package msp_pkg;

  // Saturation limit of the consumed-character count
  localparam logic [7:0] CNT_MAX = 8'd255;

  // Configuration register indexes
  localparam logic CFG_NUM_BASE  = 1'b0;
  localparam logic CFG_SUFFIX_EN = 1'b1;

  // Character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_F_LC   = 8'h66;
  localparam logic [7:0] CH_X_LC   = 8'h78;
  localparam logic [7:0] CH_K_LC   = 8'h6B;
  localparam logic [7:0] CH_M_LC   = 8'h6D;
  localparam logic [7:0] CH_G_LC   = 8'h67;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // Radix values
  localparam logic [4:0] BASE_GUESS = 5'd0;
  localparam logic [4:0] BASE_OCT   = 5'd8;
  localparam logic [4:0] BASE_DEC   = 5'd10;
  localparam logic [4:0] BASE_HEX   = 5'd16;

  // Reset values of the configuration registers
  localparam logic [4:0] NUM_BASE_RST  = BASE_GUESS;
  localparam logic       SUFFIX_EN_RST = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_of_text;
  } msp_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  consumed;
  } msp_out_t;

endpackage

FILE: src/memory_size_string_parser_unit.sv
// Memory size string parser: one character per transfer, one result per number.
// Throughput: one character per cycle, unless a result in the result register waits
// on out_stall; the 64x5 multiply-add on the accumulator sets the path.
// An input register and a result register part the two channels.
// Reset (synchronous, rst_n low) clears the pipeline, sets the parser to waiting for
// a start character and restores number_base to 0 and suffix_enable to 1.
module memory_size_string_parser_unit
  import msp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  msp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output msp_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_idx,
  input  logic [4:0] cfg_wdata
);

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_ZERO_G = 3'd2;
  localparam logic [2:0] PH_ZEROX  = 3'd3;
  localparam logic [2:0] PH_ZERO_H = 3'd4;

  logic [4:0]  num_base_r;
  logic        suffix_en_r;

  logic        in_vld_r;
  msp_in_t     in_item_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  base_r, base_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  logic        out_vld_r;
  msp_out_t    out_data_r, out_data_nxt;

  logic        res;
  logic        fire;

  // Digit decode of the held character
  logic [7:0]  ch_lc;
  logic        is_dec, is_alpha, is_hex;
  logic [3:0]  dig;

  // Shared take-digit step
  logic        td_go;
  logic [4:0]  td_b;
  logic [63:0] td_a;
  logic [7:0]  td_c;
  logic [68:0] prod;

  // Finish step
  logic        fin_go;
  logic [7:0]  fin_t, fin_lc;
  logic [63:0] fin_a;
  logic [7:0]  fin_c;

  assign ch_lc    = in_item_r.ch | CASE_BIT;
  assign is_dec   = (in_item_r.ch >= CH_ZERO) && (in_item_r.ch <= CH_NINE);
  assign is_alpha = (ch_lc >= CH_A_LC) && (ch_lc <= CH_F_LC);
  assign is_hex   = is_dec || is_alpha;
  always_comb begin
    if (is_dec) begin
      dig = 4'(in_item_r.ch - CH_ZERO);
    end else begin
      dig = 4'(ch_lc - CH_A_LC + 8'd10);
    end
  end

  // Choose the step for the held character
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    td_go     = 1'b0;
    td_b      = base_r;
    td_a      = acc_r;
    td_c      = cnt_r;
    fin_go    = 1'b0;
    fin_t     = in_item_r.ch;
    fin_a     = acc_r;
    fin_c     = cnt_r;
    if (in_item_r.start_of_text) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      base_nxt = num_base_r;
      if (in_item_r.ch == CH_ZERO && num_base_r == BASE_GUESS) begin
        cnt_nxt   = 8'd1;
        phase_nxt = PH_ZERO_G;
      end else if (in_item_r.ch == CH_ZERO && num_base_r == BASE_HEX) begin
        cnt_nxt   = 8'd1;
        phase_nxt = PH_ZERO_H;
      end else begin
        td_go = 1'b1;
        td_b  = (num_base_r == BASE_GUESS) ? BASE_DEC : num_base_r;
        td_a  = '0;
        td_c  = '0;
      end
    end else begin
      unique case (phase_r)
        PH_DIGITS: begin
          td_go = 1'b1;
        end
        PH_ZERO_G: begin
          if (ch_lc == CH_X_LC) begin
            phase_nxt = PH_ZEROX;
          end else begin
            td_go = 1'b1;
            td_b  = BASE_OCT;
          end
        end
        PH_ZEROX: begin
          if (is_hex) begin
            td_go = 1'b1;
            td_b  = BASE_HEX;
            td_c  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;
          end else begin
            // the x ends the number
            fin_go = 1'b1;
            fin_t  = CH_X_LC;
          end
        end
        PH_ZERO_H: begin
          if (ch_lc == CH_X_LC) begin
            cnt_nxt   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;
            phase_nxt = PH_DIGITS;
          end else begin
            td_go = 1'b1;
          end
        end
        default: begin
          // ignore characters after the end
        end
      endcase
    end

    // Accumulate a digit or end the number
    if (td_go) begin
      if (is_hex && ({1'b0, dig} < td_b)) begin
        acc_nxt   = prod[63:0];
        cnt_nxt   = (td_c == CNT_MAX) ? td_c : td_c + 8'd1;
        base_nxt  = td_b;
        phase_nxt = PH_DIGITS;
      end else begin
        fin_go = 1'b1;
        fin_a  = td_a;
        fin_c  = td_c;
      end
    end
  end

  assign prod = td_a * td_b + {65'd0, dig};

  // Apply the size suffix and form the result
  assign fin_lc = fin_t | CASE_BIT;
  always_comb begin
    out_data_nxt.value    = fin_a;
    out_data_nxt.consumed = fin_c;
    if (suffix_en_r) begin
      case (fin_lc)
        CH_K_LC: begin
          out_data_nxt.value    = fin_a << 10;
          out_data_nxt.consumed = (fin_c == CNT_MAX) ? fin_c : fin_c + 8'd1;
        end
        CH_M_LC: begin
          out_data_nxt.value    = fin_a << 20;
          out_data_nxt.consumed = (fin_c == CNT_MAX) ? fin_c : fin_c + 8'd1;
        end
        CH_G_LC: begin
          out_data_nxt.value    = fin_a << 30;
          out_data_nxt.consumed = (fin_c == CNT_MAX) ? fin_c : fin_c + 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res      = fin_go;
  assign fire     = in_vld_r && (!res || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_base_r  <= NUM_BASE_RST;
      suffix_en_r <= SUFFIX_EN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NUM_BASE:  num_base_r  <= cfg_wdata;
        CFG_SUFFIX_EN: suffix_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Hold the incoming transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      acc_r   <= '0;
      base_r  <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= fin_go ? PH_DONE : phase_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A result is only written when the result register is free
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res) |-> (!out_vld_r || !out_stall))
    else $error("result written over a pending result");

  // A held character is never dropped without being processed
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> in_vld_r)
    else $error("held character lost");

  // The digit phase always runs with a non-zero radix
  a_digit_base: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIGITS) |-> (base_r != 5'd0))
    else $error("digit phase with zero radix");

endmodule

FILE: tb/sv/tb_memory_size_string_parser_unit.sv
// Self-checking testbench for the memory size string parser: directed table, then random texts.
`timescale 1ns / 100ps

module tb_memory_size_string_parser_unit;
  import msp_pkg::*;

  localparam logic [7:0] NO_DIGIT = 8'hFF;
  localparam int         N_PHASES = 12;
  localparam int         PHASE_CHARS = 145;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_DIGITS,
    SCAN_ZERO,
    SCAN_ZERO_X,
    SCAN_HEX_ZERO
  } scan_state_e;

  typedef struct packed {
    logic [4:0] base;
    logic       sfx;
    logic [7:0] ch;
    logic       sot;
    logic       typed;
    msp_out_t   res;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  msp_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  msp_out_t out_data;
  logic     cfg_we;
  logic     cfg_idx;
  logic [4:0] cfg_wdata;

  // Predictor state and its copy of the registers
  scan_state_e scan_state = SCAN_IDLE;
  logic [63:0] scan_acc   = '0;
  logic [4:0]  scan_base  = '0;
  logic [7:0]  scan_count = '0;
  logic [4:0]  cfg_base   = NUM_BASE_RST;
  logic        cfg_sfx    = SUFFIX_EN_RST;

  msp_out_t expected_sizes [$];
  int       fail_count = 0;
  int       live_chars = 0;
  bit       calm = 1'b0;
  int       hold_left = 0;

  // Directed rows: reset defaults first, then prefixes, suffixes and radix extremes
  dir_row_t dir_rows [27] = '{
    '{BASE_GUESS, 1'b1, 8'h00, 1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "Z",   1'b1, 1'b1, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "k",   1'b1, 1'b1, '{64'd0, 8'd1}},
    '{BASE_GUESS, 1'b1, "0",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "x",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "g",   1'b0, 1'b1, '{64'd0, 8'd1}},
    '{BASE_GUESS, 1'b1, "x",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "0",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "X",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "F",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "f",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "K",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "1",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "2",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "3",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, " ",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, 8'hFF, 1'b1, 1'b1, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "0",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "7",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_GUESS, 1'b1, "8",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_HEX,   1'b0, "0",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{BASE_HEX,   1'b0, "x",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{BASE_HEX,   1'b0, "k",   1'b0, 1'b1, '{64'd0, 8'd2}},
    '{5'd1,       1'b1, "0",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{5'd1,       1'b1, "1",   1'b0, 1'b0, '{64'd0, 8'd0}},
    '{5'd31,      1'b1, "F",   1'b1, 1'b0, '{64'd0, 8'd0}},
    '{5'd31,      1'b1, "G",   1'b0, 1'b0, '{64'd0, 8'd0}}
  };

  memory_size_string_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Digit value of a byte, or NO_DIGIT when it is not a hex digit
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (lc >= CH_A_LC && lc <= CH_F_LC) return lc - CH_A_LC + 8'd10;
    return NO_DIGIT;
  endfunction

  function automatic void bump_count();
    if (scan_count < CNT_MAX) scan_count = scan_count + 8'd1;
  endfunction

  // End the number on byte t, applying a size suffix where enabled
  function automatic bit close_number(input logic [7:0] t, output msp_out_t r);
    logic [63:0] v;
    logic [7:0]  lc;
    int          sh;
    v  = scan_acc;
    lc = t | CASE_BIT;
    sh = 0;
    if (cfg_sfx) begin
      if (lc == CH_K_LC) sh = 10;
      else if (lc == CH_M_LC) sh = 20;
      else if (lc == CH_G_LC) sh = 30;
      if (sh != 0) begin
        v = v << sh;
        bump_count();
      end
    end
    r.value    = v;
    r.consumed = scan_count;
    scan_state = SCAN_IDLE;
    return 1'b1;
  endfunction

  // Accumulate a digit of the running radix, or end the number
  function automatic bit digit_or_close(input logic [7:0] c, output msp_out_t r);
    logic [7:0] d;
    d = hex_value(c);
    r = '0;
    if (d == NO_DIGIT || d >= scan_base) return close_number(c, r);
    scan_acc = scan_acc * scan_base + d;
    bump_count();
    scan_state = SCAN_DIGITS;
    return 1'b0;
  endfunction

  // Advance the predicted parser by one byte; returns 1 when a result is due
  function automatic bit scan_char(input logic [7:0] c, input logic s, output msp_out_t r);
    r = '0;
    if (s) begin
      scan_acc   = '0;
      scan_count = '0;
      scan_base  = cfg_base;
      if (c == CH_ZERO && scan_base == BASE_GUESS) begin
        scan_count = 8'd1;
        scan_state = SCAN_ZERO;
        return 1'b0;
      end
      if (c == CH_ZERO && scan_base == BASE_HEX) begin
        scan_count = 8'd1;
        scan_state = SCAN_HEX_ZERO;
        return 1'b0;
      end
      if (scan_base == BASE_GUESS) scan_base = BASE_DEC;
      return digit_or_close(c, r);
    end
    case (scan_state)
      SCAN_DIGITS: return digit_or_close(c, r);
      SCAN_ZERO: begin
        if ((c | CASE_BIT) == CH_X_LC) begin
          scan_state = SCAN_ZERO_X;
          return 1'b0;
        end
        scan_base = BASE_OCT;
        return digit_or_close(c, r);
      end
      SCAN_ZERO_X: begin
        if (hex_value(c) != NO_DIGIT) begin
          scan_base = BASE_HEX;
          bump_count();
          return digit_or_close(c, r);
        end
        // the x itself ends the number and is never a suffix
        return close_number(CH_X_LC, r);
      end
      SCAN_HEX_ZERO: begin
        if ((c | CASE_BIT) == CH_X_LC) begin
          bump_count();
          scan_state = SCAN_DIGITS;
          return 1'b0;
        end
        return digit_or_close(c, r);
      end
      default: return 1'b0;
    endcase
  endfunction

  // Random digit character valid for the given radix
  function automatic logic [7:0] rand_digit(input logic [4:0] radix);
    int top;
    int d;
    top = (radix > 16) ? 16 : ((radix == 0) ? 10 : int'(radix));
    d   = $urandom_range(0, top - 1);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'((CH_A_LC ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00)) + d - 10);
  endfunction

  // Offer one character; on transfer, record what it should produce
  task automatic send_char(input logic [7:0] c, input logic s, input logic typed,
                           input msp_out_t typed_res);
    msp_out_t pred;
    bit       due;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.ch            = c;
    in_data.start_of_text = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    live_chars++;
    due = scan_char(c, s, pred);
    if (typed) expected_sizes.push_back(typed_res);
    else if (due) expected_sizes.push_back(pred);
  endtask

  // Drain the block, then write both registers
  task automatic set_config(input logic [4:0] b, input logic s);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_sizes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_NUM_BASE;
    cfg_wdata = b;
    @(negedge clk);
    cfg_idx   = CFG_SUFFIX_EN;
    cfg_wdata = {4'b0000, s};
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_base = b;
    cfg_sfx  = s;
  endtask

  // Result side back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    msp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sizes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h consumed %0d",
                 $time, out_data.value, out_data.consumed);
        fail_count++;
      end else begin
        want = expected_sizes.pop_front();
        if (want.value !== out_data.value) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, want.value, out_data.value);
          fail_count++;
        end
        if (want.consumed !== out_data.consumed) begin
          $display("%0t: consumed mismatch: expected %0d, actual %0d",
                   $time, want.consumed, out_data.consumed);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [4:0] phase_base [N_PHASES];
    logic       phase_sfx  [N_PHASES];
    logic [4:0] eff;
    logic       sot_pend;
    logic [7:0] c;
    int         target;
    int         ndig;
    int         n;

    phase_base = '{BASE_GUESS, BASE_HEX, BASE_DEC, 5'd1, 5'd31,
                   BASE_OCT, BASE_GUESS, BASE_HEX, 5'd0, 5'd0,
                   5'd0, BASE_GUESS};
    phase_sfx  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                   1'b0, 1'b0, 1'b0, 1'b1};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_NUM_BASE;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].base != cfg_base || dir_rows[i].sfx != cfg_sfx)
        set_config(dir_rows[i].base, dir_rows[i].sfx);
      send_char(dir_rows[i].ch, dir_rows[i].sot, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random texts, one register setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      if (p >= 8 && p <= 10) begin
        phase_base[p] = 5'($urandom_range(0, 31));
        phase_sfx[p]  = 1'($urandom_range(0, 1));
      end
      set_config(phase_base[p], phase_sfx[p]);
      calm   = (p == N_PHASES - 1) || ($urandom_range(0, 5) == 0);
      target = live_chars + PHASE_CHARS;
      while (live_chars < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary bytes and start flags
          n = $urandom_range(1, 6);
          repeat (n) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               1'b0, '0);
        end else begin
          eff      = cfg_base;
          sot_pend = ($urandom_range(0, 14) != 0);
          if (cfg_base == BASE_GUESS) begin
            case ($urandom_range(0, 3))
              0: begin
                send_char(CH_ZERO, sot_pend, 1'b0, '0);
                send_char(CH_X_LC ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00), 1'b0,
                          1'b0, '0);
                eff = BASE_HEX;
              end
              1: begin
                send_char(CH_ZERO, sot_pend, 1'b0, '0);
                eff = BASE_OCT;
              end
              2: begin
                send_char(8'($urandom_range(CH_ZERO + 1, CH_NINE)), sot_pend, 1'b0, '0);
                eff = BASE_DEC;
              end
              default: begin
                // broken prefix: zero, x, then mostly a non-hex byte
                send_char(CH_ZERO, sot_pend, 1'b0, '0);
                send_char(CH_X_LC, 1'b0, 1'b0, '0);
                send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                eff = BASE_HEX;
              end
            endcase
            sot_pend = 1'b0;
          end else if (cfg_base == BASE_HEX && $urandom_range(0, 1)) begin
            send_char(CH_ZERO, sot_pend, 1'b0, '0);
            send_char(CH_X_LC ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00), 1'b0, 1'b0, '0);
            sot_pend = 1'b0;
          end
          // mostly short digit runs; now and then one long enough to wrap and saturate
          ndig = ($urandom_range(0, 79) == 0) ? $urandom_range(17, 280) : $urandom_range(0, 8);
          for (int k = 0; k < ndig; k++) begin
            c = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : rand_digit(eff);
            send_char(c, sot_pend, 1'b0, '0);
            sot_pend = 1'b0;
          end
          // terminate with a suffix, a random byte, or let the next start cut in
          case ($urandom_range(0, 2))
            0: begin
              case ($urandom_range(0, 2))
                0:       c = CH_K_LC;
                1:       c = CH_M_LC;
                default: c = CH_G_LC;
              endcase
              if ($urandom_range(0, 1)) c = c ^ CASE_BIT;
              send_char(c, sot_pend, 1'b0, '0);
            end
            1: send_char(8'($urandom_range(0, 255)), sot_pend, 1'b0, '0);
            default: ;
          endcase
          n = $urandom_range(0, 3);
          repeat (n) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
      end
    end

    // Drain and settle
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_sizes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: memory_size_string_parser_unit.f
src/msp_pkg.sv
src/memory_size_string_parser_unit.sv
tb/sv/tb_memory_size_string_parser_unit.sv
